[rtl/core/shp_pkg.sv]
// ----------------------------------------------------------------------------
// shp_pkg
// Shared constants, register codes and control types of the 3x3 sharpen
// filter.
// ----------------------------------------------------------------------------
package shp_pkg;

    localparam int MAX_WIDTH_DEF      = 4096;
    localparam int CHANNEL_BITS_DEF   = 16;

    localparam int PORT_BITS          = 16;
    localparam int CENTER_GAIN_BITS   = 23;
    localparam int NEIGHBOR_GAIN_BITS = 21;
    localparam int WIDTH_BITS         = 13;
    localparam int HEIGHT_BITS        = 16;
    localparam int ROW_BITS           = HEIGHT_BITS + 1;
    localparam int CMP_BITS           = 17;
    localparam int CFG_INDEX_BITS     = 2;
    localparam int CFG_DATA_BITS      = 23;
    localparam int FRAC_BITS          = 16;
    localparam int ROUND_HALF         = 1 << (FRAC_BITS - 1);

    localparam logic [CENTER_GAIN_BITS-1:0]          CENTER_GAIN_RST   = 23'd72818;
    localparam logic signed [NEIGHBOR_GAIN_BITS-1:0] NEIGHBOR_GAIN_RST = -21'sd910;
    localparam logic [WIDTH_BITS-1:0]                IMAGE_WIDTH_RST   = 13'd640;
    localparam logic [HEIGHT_BITS-1:0]               IMAGE_HEIGHT_RST  = 16'd480;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_CENTER_GAIN   = 2'd0,
        CFG_NEIGHBOR_GAIN = 2'd1,
        CFG_IMAGE_WIDTH   = 2'd2,
        CFG_IMAGE_HEIGHT  = 2'd3
    } shp_cfg_index_t;

    typedef struct packed {
        logic [CENTER_GAIN_BITS-1:0]          center_gain;
        logic signed [NEIGHBOR_GAIN_BITS-1:0] neighbor_gain;
        logic [WIDTH_BITS-1:0]                image_width;
        logic [HEIGHT_BITS-1:0]               image_height;
    } shp_cfg_t;

    // What one accepted pixel asks of the window stage.
    typedef struct packed {
        logic emit;
        logic pre_shift;
        logic left_edge;
        logic top;
        logic bottom;
        logic last;
    } shp_emit_t;

endpackage

[rtl/core/sharpen_3x3_rgba_filter.sv]
// ----------------------------------------------------------------------------
// sharpen_3x3_rgba_filter
// 3x3 sharpen over a raster RGBA stream with two line stores, edge
// replication on all sides and a saturating Q16 gain stage.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Payload
//  in        in_valid / in_ready    mode, red_in, green_in, blue_in, alpha_in
//  out       out_valid / out_ready  red_out, green_out, blue_out, alpha_out,
//                                   frame_end
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One item per clock cycle when the output is taken. A result passes the
//  input register, line store read and tap register, neighbor sum, multiply
//  and round/saturate on its way into the output register.
//  Reset clears counters, window and valid bits and loads register defaults;
//  the line stores are not cleared. cfg_ready is always high. A stalled
//  output fills the stages behind it, and in_ready drops once the input
//  register cannot move on.
// ----------------------------------------------------------------------------
module sharpen_3x3_rgba_filter #(
    parameter int MAX_WIDTH    = shp_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = shp_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  mode,
    input  logic [shp_pkg::PORT_BITS-1:0]         red_in,
    input  logic [shp_pkg::PORT_BITS-1:0]         green_in,
    input  logic [shp_pkg::PORT_BITS-1:0]         blue_in,
    input  logic [shp_pkg::PORT_BITS-1:0]         alpha_in,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [shp_pkg::PORT_BITS-1:0]         red_out,
    output logic [shp_pkg::PORT_BITS-1:0]         green_out,
    output logic [shp_pkg::PORT_BITS-1:0]         blue_out,
    output logic [shp_pkg::PORT_BITS-1:0]         alpha_out,
    output logic                                  frame_end,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [shp_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [shp_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import shp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = 4 * CHANNEL_BITS;

    shp_cfg_t           cfg_reg;
    logic [PW-1:0]      pix_in;
    logic               rd_en;
    logic [CW-1:0]      rd_addr;
    logic               a_valid;
    logic [CW-1:0]      a_col;
    logic [PW-1:0]      a_pix;
    shp_emit_t          a_emit;
    logic               a_advance;
    logic               b_valid;
    logic [9*PW-1:0]    b_taps;
    logic               b_last;
    logic               b_ready;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_gain   <= CENTER_GAIN_RST;
            cfg_reg.neighbor_gain <= NEIGHBOR_GAIN_RST;
            cfg_reg.image_width   <= IMAGE_WIDTH_RST;
            cfg_reg.image_height  <= IMAGE_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (shp_cfg_index_t'(cfg_index))
                CFG_CENTER_GAIN:   cfg_reg.center_gain   <= cfg_data[CENTER_GAIN_BITS-1:0];
                CFG_NEIGHBOR_GAIN: cfg_reg.neighbor_gain <= cfg_data[NEIGHBOR_GAIN_BITS-1:0];
                CFG_IMAGE_WIDTH:   cfg_reg.image_width   <= cfg_data[WIDTH_BITS-1:0];
                CFG_IMAGE_HEIGHT:  cfg_reg.image_height  <= cfg_data[HEIGHT_BITS-1:0];
            endcase
        end
    end

    // Red sits in the low channel slot, alpha in the high one.
    assign pix_in = {alpha_in[CHANNEL_BITS-1:0], blue_in[CHANNEL_BITS-1:0],
                     green_in[CHANNEL_BITS-1:0], red_in[CHANNEL_BITS-1:0]};

    shp_sequencer #(
        .MAX_WIDTH    (MAX_WIDTH),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_sequencer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .pix_in    (pix_in),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .a_valid   (a_valid),
        .a_col     (a_col),
        .a_pix     (a_pix),
        .a_emit    (a_emit),
        .a_advance (a_advance)
    );

    shp_window #(
        .MAX_WIDTH    (MAX_WIDTH),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .a_valid   (a_valid),
        .a_col     (a_col),
        .a_pix     (a_pix),
        .a_emit    (a_emit),
        .a_advance (a_advance),
        .b_valid   (b_valid),
        .b_taps    (b_taps),
        .b_last    (b_last),
        .b_ready   (b_ready)
    );

    shp_kernel #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_kernel (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .b_valid   (b_valid),
        .b_taps    (b_taps),
        .b_last    (b_last),
        .b_ready   (b_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .alpha_out (alpha_out),
        .frame_end (frame_end)
    );

endmodule

[rtl/core/shp_sequencer.sv]
// ----------------------------------------------------------------------------
// shp_sequencer
// Raster position counters, per-item decisions and the input register.
// ----------------------------------------------------------------------------
module shp_sequencer #(
    parameter int MAX_WIDTH    = shp_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = shp_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  shp_pkg::shp_cfg_t                     cfg,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  mode,
    input  logic [4*CHANNEL_BITS-1:0]             pix_in,
    output logic                                  rd_en,
    output logic [$clog2(MAX_WIDTH)-1:0]          rd_addr,
    output logic                                  a_valid,
    output logic [$clog2(MAX_WIDTH)-1:0]          a_col,
    output logic [4*CHANNEL_BITS-1:0]             a_pix,
    output shp_pkg::shp_emit_t                    a_emit,
    input  logic                                  a_advance
);
    import shp_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int PW = 4 * CHANNEL_BITS;

    logic [CW-1:0]          col_reg, col_next;
    logic [ROW_BITS-1:0]    row_reg, row_next;
    logic                   a_valid_reg, a_valid_next;
    logic [CW-1:0]          a_col_reg;
    logic [PW-1:0]          a_pix_reg;
    shp_emit_t              a_emit_reg, emit_next;

    logic [CMP_BITS-1:0]    w_wide, w_lim, col_inc;
    logic [HEIGHT_BITS-1:0] h_eff;
    logic [ROW_BITS-1:0]    h_row, h_top, row_out;
    logic [CW-1:0]          c_eff;
    logic [ROW_BITS-1:0]    r_eff;
    logic                   draining, ignore, enter, emit_pre, emit_post;

    always_comb
    begin
        w_wide = CMP_BITS'(cfg.image_width);
        if (w_wide < CMP_BITS'(2))
            w_lim = CMP_BITS'(2);
        else if (w_wide > CMP_BITS'(MAX_WIDTH))
            w_lim = CMP_BITS'(MAX_WIDTH);
        else
            w_lim = w_wide;

        h_eff = (cfg.image_height < HEIGHT_BITS'(2)) ? HEIGHT_BITS'(2) : cfg.image_height;
        h_row = ROW_BITS'(h_eff);
        h_top = h_row + ROW_BITS'(1);

        // Counters left out of range by a size change restart at zero.
        c_eff = (CMP_BITS'(col_reg) >= w_lim) ? '0 : col_reg;
        r_eff = (row_reg > h_top) ? '0 : row_reg;

        draining = (r_eff >= h_row);
        ignore   = !draining && mode;
        enter    = in_valid && in_ready && !ignore;

        emit_pre  = (c_eff == '0) && (r_eff >= ROW_BITS'(2));
        emit_post = (c_eff != '0) && (r_eff != '0);
        row_out   = emit_pre ? r_eff - ROW_BITS'(2) : r_eff - ROW_BITS'(1);

        emit_next.emit      = emit_pre || emit_post;
        emit_next.pre_shift = emit_pre;
        emit_next.left_edge = (c_eff == CW'(1));
        emit_next.top       = (row_out == '0);
        emit_next.bottom    = (row_out == h_row - ROW_BITS'(1));
        emit_next.last      = emit_pre && (row_out == h_row - ROW_BITS'(1));

        col_inc = CMP_BITS'(c_eff) + CMP_BITS'(1);
        if (r_eff == h_top)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_inc >= w_lim)
        begin
            col_next = '0;
            row_next = r_eff + ROW_BITS'(1);
        end
        else
        begin
            col_next = CW'(col_inc);
            row_next = r_eff;
        end

        if (enter)
            a_valid_next = 1'b1;
        else if (a_advance)
            a_valid_next = 1'b0;
        else
            a_valid_next = a_valid_reg;
    end

    assign in_ready = !a_valid_reg || a_advance;
    assign rd_en    = enter;
    assign rd_addr  = c_eff;
    assign a_valid  = a_valid_reg;
    assign a_col    = a_col_reg;
    assign a_pix    = a_pix_reg;
    assign a_emit   = a_emit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (enter)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enter)
        begin
            a_col_reg  <= c_eff;
            a_pix_reg  <= draining ? '0 : pix_in;
            a_emit_reg <= emit_next;
        end
    end

endmodule

[rtl/core/shp_window.sv]
// ----------------------------------------------------------------------------
// shp_window
// Line store memory, 3x3 window shift register and edge-replicated tap
// selection into the tap register.
// ----------------------------------------------------------------------------
module shp_window #(
    parameter int MAX_WIDTH    = shp_pkg::MAX_WIDTH_DEF,
    parameter int CHANNEL_BITS = shp_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]          rd_addr,
    input  logic                                  a_valid,
    input  logic [$clog2(MAX_WIDTH)-1:0]          a_col,
    input  logic [4*CHANNEL_BITS-1:0]             a_pix,
    input  shp_pkg::shp_emit_t                    a_emit,
    output logic                                  a_advance,
    output logic                                  b_valid,
    output logic [9*4*CHANNEL_BITS-1:0]           b_taps,
    output logic                                  b_last,
    input  logic                                  b_ready
);
    import shp_pkg::*;

    localparam int PW = 4 * CHANNEL_BITS;

    // Each entry holds the upper line pixel above the middle line pixel.
    logic [2*PW-1:0] line_mem [MAX_WIDTH];
    logic [2*PW-1:0] rd_data_reg;
    logic [2*PW-1:0] wr_data;
    logic            wr_en;

    logic [PW-1:0]   win_reg  [9];
    logic [PW-1:0]   win_next [9];
    logic [PW-1:0]   row_sel  [3][3];
    logic [PW-1:0]   tap      [9];
    logic [9*PW-1:0] b_taps_next;
    logic [9*PW-1:0] b_taps_reg;
    logic            b_valid_reg;
    logic            b_last_reg;
    logic            b_free;

    assign b_free    = !b_valid_reg || b_ready;
    assign a_advance = a_valid && (!a_emit.emit || b_free);
    assign wr_en     = a_advance;
    assign wr_data   = {rd_data_reg[PW-1:0], a_pix};

    // A read that hits the column written in the same cycle takes the new data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[a_col] <= wr_data;
        if (rd_en)
            rd_data_reg <= (wr_en && (a_col == rd_addr)) ? wr_data : line_mem[rd_addr];
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i*3]     = win_reg[i*3 + 1];
            win_next[i*3 + 1] = win_reg[i*3 + 2];
        end
        win_next[2] = rd_data_reg[2*PW-1:PW];
        win_next[5] = rd_data_reg[PW-1:0];
        win_next[8] = a_pix;

        for (int k = 0; k < 3; k++)
        begin
            row_sel[0][k] = a_emit.top ? win_next[3 + k] : win_next[k];
            row_sel[1][k] = win_next[3 + k];
            row_sel[2][k] = a_emit.bottom ? win_next[3 + k] : win_next[6 + k];
        end

        // After the shift, the pre-shift columns one and two sit in columns
        // zero and one, so both kinds of result read the shifted window.
        for (int i = 0; i < 3; i++)
        begin
            tap[i*3]     = (!a_emit.pre_shift && a_emit.left_edge) ? row_sel[i][1]
                                                                   : row_sel[i][0];
            tap[i*3 + 1] = row_sel[i][1];
            tap[i*3 + 2] = a_emit.pre_shift ? row_sel[i][1] : row_sel[i][2];
        end

        for (int t = 0; t < 9; t++)
            b_taps_next[t*PW +: PW] = tap[t];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_advance)
                for (int i = 0; i < 9; i++)
                    win_reg[i] <= win_next[i];
            if (b_free)
                b_valid_reg <= a_valid && a_emit.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_advance && a_emit.emit)
        begin
            b_taps_reg <= b_taps_next;
            b_last_reg <= a_emit.last;
        end
    end

    assign b_valid = b_valid_reg;
    assign b_taps  = b_taps_reg;
    assign b_last  = b_last_reg;

endmodule

[rtl/core/shp_kernel.sv]
// ----------------------------------------------------------------------------
// shp_kernel
// Neighbor sum, gain multiply, rounding and saturation, ending in the
// output register.
// ----------------------------------------------------------------------------
module shp_kernel #(
    parameter int CHANNEL_BITS = shp_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  shp_pkg::shp_cfg_t                     cfg,
    input  logic                                  b_valid,
    input  logic [9*4*CHANNEL_BITS-1:0]           b_taps,
    input  logic                                  b_last,
    output logic                                  b_ready,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [shp_pkg::PORT_BITS-1:0]         red_out,
    output logic [shp_pkg::PORT_BITS-1:0]         green_out,
    output logic [shp_pkg::PORT_BITS-1:0]         blue_out,
    output logic [shp_pkg::PORT_BITS-1:0]         alpha_out,
    output logic                                  frame_end
);
    import shp_pkg::*;

    localparam int CB         = CHANNEL_BITS;
    localparam int PW         = 4 * CB;
    localparam int SW         = CB + 3;
    localparam int CPW        = CB + CENTER_GAIN_BITS;
    localparam int NPW        = SW + 1 + NEIGHBOR_GAIN_BITS;
    localparam int AW         = NPW + 1;
    localparam int CENTER_TAP = 4;
    localparam logic [CB-1:0] CH_MAX = '1;

    logic                     c_valid_reg, d_valid_reg, out_valid_reg;
    logic                     c_free, d_free, e_free;

    logic [CB-1:0]            center_next  [3];
    logic [SW-1:0]            nsum_next    [3];
    logic [CB-1:0]            c_center_reg [3];
    logic [SW-1:0]            c_nsum_reg   [3];
    logic [CB-1:0]            c_alpha_reg;
    logic                     c_last_reg;

    logic [CPW-1:0]           prod_c_next  [3];
    logic signed [NPW-1:0]    prod_n_next  [3];
    logic [CPW-1:0]           d_prod_c_reg [3];
    logic signed [NPW-1:0]    d_prod_n_reg [3];
    logic [CB-1:0]            d_alpha_reg;
    logic                     d_last_reg;

    logic signed [AW-1:0]     acc [3];
    logic [AW-1:0]            rnd [3];
    logic [CB-1:0]            chan_next    [3];
    logic [CB-1:0]            out_chan_reg [3];
    logic [CB-1:0]            out_alpha_reg;
    logic                     out_last_reg;

    assign e_free  = !out_valid_reg || out_ready;
    assign d_free  = !d_valid_reg || e_free;
    assign c_free  = !c_valid_reg || d_free;
    assign b_ready = c_free;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            center_next[k] = b_taps[CENTER_TAP*PW + k*CB +: CB];
            nsum_next[k]   = '0;
            for (int t = 0; t < 9; t++)
                if (t != CENTER_TAP)
                    nsum_next[k] = nsum_next[k] + SW'(b_taps[t*PW + k*CB +: CB]);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            prod_c_next[k] = CPW'(c_center_reg[k]) * CPW'(cfg.center_gain);
            prod_n_next[k] = NPW'($signed({1'b0, c_nsum_reg[k]})) * NPW'(cfg.neighbor_gain);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            acc[k] = AW'($signed({1'b0, d_prod_c_reg[k]})) + AW'(d_prod_n_reg[k]);
            rnd[k] = $unsigned(acc[k]) + AW'(ROUND_HALF);
            if (acc[k][AW-1])
                chan_next[k] = '0;
            else if ((rnd[k] >> FRAC_BITS) > AW'(CH_MAX))
                chan_next[k] = CH_MAX;
            else
                chan_next[k] = CB'(rnd[k] >> FRAC_BITS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (c_free)
                c_valid_reg <= b_valid;
            if (d_free)
                d_valid_reg <= c_valid_reg;
            if (e_free)
                out_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_free && b_valid)
        begin
            for (int k = 0; k < 3; k++)
            begin
                c_center_reg[k] <= center_next[k];
                c_nsum_reg[k]   <= nsum_next[k];
            end
            c_alpha_reg <= b_taps[CENTER_TAP*PW + 3*CB +: CB];
            c_last_reg  <= b_last;
        end
        if (d_free && c_valid_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                d_prod_c_reg[k] <= prod_c_next[k];
                d_prod_n_reg[k] <= prod_n_next[k];
            end
            d_alpha_reg <= c_alpha_reg;
            d_last_reg  <= c_last_reg;
        end
        if (e_free && d_valid_reg)
        begin
            for (int k = 0; k < 3; k++)
                out_chan_reg[k] <= chan_next[k];
            out_alpha_reg <= d_alpha_reg;
            out_last_reg  <= d_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = PORT_BITS'(out_chan_reg[0]);
    assign green_out = PORT_BITS'(out_chan_reg[1]);
    assign blue_out  = PORT_BITS'(out_chan_reg[2]);
    assign alpha_out = PORT_BITS'(out_alpha_reg);
    assign frame_end = out_last_reg;

endmodule

[bench/sharpen_3x3_rgba_filter_tb.sv]
// ----------------------------------------------------------------------------
// sharpen_3x3_rgba_filter_tb
// Self-checking bench for the 3x3 RGBA sharpen filter. A cycle-free model of
// the window, the line history and the Q16 gain stage predicts every output
// pixel from the accepted input items. A monitor checks the results in order.
// Directed frames cover gain and size extremes, flushes and a mid-frame size
// change. Random frames then run under several idle and stall patterns, and
// a partial line at the widest size setting closes the run.
// ----------------------------------------------------------------------------
module sharpen_3x3_rgba_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import shp_pkg::*;

    localparam int LINE_DEPTH  = MAX_WIDTH_DEF;
    localparam int CH_MAX      = (1 << CHANNEL_BITS_DEF) - 1;
    localparam int HOLD_OFF    = 12;
    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic [PORT_BITS-1:0] red;
        logic [PORT_BITS-1:0] green;
        logic [PORT_BITS-1:0] blue;
        logic [PORT_BITS-1:0] alpha;
        logic                 frame_end;
    } sharpened_pixel_t;

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      in_valid   = 1'b0;
    logic                      in_ready;
    logic                      mode       = 1'b0;
    logic [PORT_BITS-1:0]      red_in     = '0;
    logic [PORT_BITS-1:0]      green_in   = '0;
    logic [PORT_BITS-1:0]      blue_in    = '0;
    logic [PORT_BITS-1:0]      alpha_in   = '0;
    logic                      out_valid;
    logic                      out_ready  = 1'b0;
    logic [PORT_BITS-1:0]      red_out;
    logic [PORT_BITS-1:0]      green_out;
    logic [PORT_BITS-1:0]      blue_out;
    logic [PORT_BITS-1:0]      alpha_out;
    logic                      frame_end;
    logic                      cfg_valid  = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index  = CFG_CENTER_GAIN;
    logic [CFG_DATA_BITS-1:0]  cfg_data   = '0;

    // Model state: line history, 3x3 taps, position and register copies.
    logic [63:0]                          upper_hist [LINE_DEPTH];
    logic [63:0]                          middle_hist [LINE_DEPTH];
    logic [63:0]                          taps [9];
    int unsigned                          col_pos;
    int unsigned                          row_pos;
    logic [CENTER_GAIN_BITS-1:0]          center_gain_m;
    logic signed [NEIGHBOR_GAIN_BITS-1:0] neighbor_gain_m;
    logic [WIDTH_BITS-1:0]                width_reg;
    logic [HEIGHT_BITS-1:0]               height_reg;

    sharpened_pixel_t expected_pixels [$];

    int error_count        = 0;
    int items_sent         = 0;
    int quiet_cycles       = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    sharpen_3x3_rgba_filter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .alpha_in  (alpha_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .alpha_out (alpha_out),
        .frame_end (frame_end),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk) out_ready <= ($urandom_range(99) >= receiver_stall_pct);

    function automatic int unsigned clamp_width(logic [WIDTH_BITS-1:0] w);
        if (w < 2)
            return 2;
        if (w > LINE_DEPTH)
            return LINE_DEPTH;
        return w;
    endfunction

    function automatic int unsigned clamp_height(logic [HEIGHT_BITS-1:0] h);
        return (h < 2) ? 2 : h;
    endfunction

    function automatic logic [PORT_BITS-1:0] gained_channel(longint center, longint nsum);
        longint acc;
        acc = center * longint'(center_gain_m) + nsum * longint'(neighbor_gain_m);
        if (acc < 0)
            return '0;
        acc = (acc + ROUND_HALF) >>> FRAC_BITS;
        return (acc > CH_MAX) ? PORT_BITS'(CH_MAX) : PORT_BITS'(acc);
    endfunction

    // Rows and columns pick taps so that edge pixels stand in for missing ones.
    function automatic void queue_window_result(int cl, int cc, int cr,
                                                bit top, bit bottom, bit last);
        int               rows [3];
        int               cols [3];
        int               i;
        int               j;
        int               k;
        longint           center;
        longint           nsum;
        logic [PORT_BITS-1:0] ch [3];
        sharpened_pixel_t res;
        rows = '{top ? 1 : 0, 1, bottom ? 1 : 2};
        cols = '{cl, cc, cr};
        for (k = 0; k < 3; k++) begin
            center = taps[3 + cc][PORT_BITS*k +: PORT_BITS];
            nsum = 0;
            for (i = 0; i < 3; i++)
                for (j = 0; j < 3; j++)
                    if (i != 1 || j != 1)
                        nsum += taps[rows[i]*3 + cols[j]][PORT_BITS*k +: PORT_BITS];
            ch[k] = gained_channel(center, nsum);
        end
        res.red       = ch[0];
        res.green     = ch[1];
        res.blue      = ch[2];
        res.alpha     = taps[3 + cc][PORT_BITS*3 +: PORT_BITS];
        res.frame_end = last;
        expected_pixels.push_back(res);
    endfunction

    function automatic void sharpen_predict(logic md, logic [PORT_BITS-1:0] px_red,
                                            logic [PORT_BITS-1:0] px_green,
                                            logic [PORT_BITS-1:0] px_blue,
                                            logic [PORT_BITS-1:0] px_alpha);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int          i;
        logic [63:0] px;
        bit          draining;
        w = clamp_width(width_reg);
        h = clamp_height(height_reg);
        if (col_pos >= w)
            col_pos = 0;
        if (row_pos > h + 1)
            row_pos = 0;
        c = col_pos;
        r = row_pos;
        draining = (r >= h);
        // A flush inside the frame is ignored; once draining, every item flushes.
        if (!draining && md)
            return;
        px = draining ? 64'd0 : {px_alpha, px_blue, px_green, px_red};
        // The right-edge pixel of row r-2 comes from the window before the shift.
        if (c == 0 && r >= 2)
            queue_window_result(1, 2, 2, r - 2 == 0, r - 2 == h - 1, r - 2 == h - 1);
        for (i = 0; i < 3; i++) begin
            taps[i*3]     = taps[i*3 + 1];
            taps[i*3 + 1] = taps[i*3 + 2];
        end
        taps[2] = upper_hist[c];
        taps[5] = middle_hist[c];
        taps[8] = px;
        upper_hist[c]  = middle_hist[c];
        middle_hist[c] = px;
        if (c >= 1 && r >= 1)
            queue_window_result(c == 1 ? 1 : 0, 1, 2, r - 1 == 0, r - 1 == h - 1, 1'b0);
        if (r == h + 1) begin
            col_pos = 0;
            row_pos = 0;
        end
        else begin
            c++;
            if (c >= w) begin
                c = 0;
                r++;
            end
            col_pos = c;
            row_pos = r;
        end
    endfunction

    function automatic void mirror_register(logic [CFG_INDEX_BITS-1:0] idx,
                                            logic [CFG_DATA_BITS-1:0] data);
        case (shp_cfg_index_t'(idx))
            CFG_CENTER_GAIN:   center_gain_m   = data[CENTER_GAIN_BITS-1:0];
            CFG_NEIGHBOR_GAIN: neighbor_gain_m = data[NEIGHBOR_GAIN_BITS-1:0];
            CFG_IMAGE_WIDTH:   width_reg       = data[WIDTH_BITS-1:0];
            CFG_IMAGE_HEIGHT:  height_reg      = data[HEIGHT_BITS-1:0];
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                mirror_register(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sharpen_predict(mode, red_in, green_in, blue_in, alpha_in);
            if (out_valid && out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("result with nothing expected: red_out %0d, frame_end %0d",
                           red_out, frame_end);
                    error_count++;
                end
                else begin
                    check_field("red_out", expected_pixels[0].red, red_out);
                    check_field("green_out", expected_pixels[0].green, green_out);
                    check_field("blue_out", expected_pixels[0].blue, blue_out);
                    check_field("alpha_out", expected_pixels[0].alpha, alpha_out);
                    check_field("frame_end", expected_pixels[0].frame_end, frame_end);
                    void'(expected_pixels.pop_front());
                end
            end
            quiet_cycles <= ((cfg_valid && cfg_ready) || (in_valid && in_ready) ||
                             (out_valid && out_ready)) ? 0 : quiet_cycles + 1;
        end
    end

    initial begin
        wait (rst_n === 1'b1);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    function automatic logic [PORT_BITS-1:0] draw_channel();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return '1;
            default: return PORT_BITS'($urandom);
        endcase
    endfunction

    // Leaves in_valid high after acceptance so that a back-to-back item needs
    // no second assignment in the same step.
    task automatic send_item(logic md, logic [PORT_BITS-1:0] r, logic [PORT_BITS-1:0] g,
                             logic [PORT_BITS-1:0] b, logic [PORT_BITS-1:0] a);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= md;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        alpha_in <= a;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_pixels(int count, int noise_pct);
        int n;
        for (n = 0; n < count; n++) begin
            if ($urandom_range(99) < noise_pct)
                send_item(1'b1, PORT_BITS'($urandom), PORT_BITS'($urandom),
                          PORT_BITS'($urandom), PORT_BITS'($urandom));
            send_item(1'b0, draw_channel(), draw_channel(), draw_channel(), draw_channel());
        end
        items_sent += count;
    endtask

    // One frame of random pixels, then the width+1 items that drain it.
    task automatic send_frame(int unsigned w, int unsigned h, int noise_pct);
        int n;
        send_pixels(w * h, noise_pct);
        for (n = 0; n <= w; n++)
            send_item(1'($urandom_range(0, 1)), draw_channel(), draw_channel(),
                      draw_channel(), draw_channel());
        items_sent += w + 1;
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        // The monitor may not yet have queued the item accepted at this edge.
        @(posedge clk);
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    task automatic write_register(shp_cfg_index_t idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    // Registers are only written with nothing left in flight.
    task automatic program_registers(bit with_gains, logic [CFG_DATA_BITS-1:0] cg,
                                     logic [CFG_DATA_BITS-1:0] ng,
                                     logic [CFG_DATA_BITS-1:0] w,
                                     logic [CFG_DATA_BITS-1:0] h);
        wait_for_drain();
        if (with_gains) begin
            write_register(CFG_CENTER_GAIN, cg);
            write_register(CFG_NEIGHBOR_GAIN, ng);
        end
        write_register(CFG_IMAGE_WIDTH, w);
        write_register(CFG_IMAGE_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    // Mostly gains as software derives them from a sharpen amount.
    function automatic void draw_gains(output logic [CFG_DATA_BITS-1:0] cg,
                                       output logic [CFG_DATA_BITS-1:0] ng);
        int amount;
        int center;
        int neighbor;
        if ($urandom_range(0, 9) == 0) begin
            cg = CFG_DATA_BITS'($urandom);
            ng = CFG_DATA_BITS'($urandom);
        end
        else begin
            amount   = $urandom_range(0, 99);
            center   = 6553600 / (100 - amount);
            neighbor = (65536 - center) / 8;
            cg = CFG_DATA_BITS'(center);
            ng = {2'($urandom), NEIGHBOR_GAIN_BITS'(neighbor)};
        end
    endfunction

    task automatic test_default_gains();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        program_registers(1'b0, '0, '0, 2, 2);
        send_item(1'b0, '0, '0, '0, '0);
        // A flush before the frame is complete must be ignored.
        send_item(1'b1, '1, '1, '1, '1);
        send_item(1'b0, '1, '1, '1, '1);
        send_item(1'b0, '1, '0, '1, '0);
        send_item(1'b0, '0, '1, 16'h8000, 16'h7fff);
        send_item(1'b1, '0, '0, '0, '0);
        // A pixel while draining acts as a flush and its data is dropped.
        send_item(1'b0, 16'h1234, 16'h5678, 16'h9abc, 16'hdef0);
        send_item(1'b1, '0, '0, '0, '0);
    endtask

    task automatic test_gain_extremes();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        // Largest center gain with the largest positive neighbor gain saturates high.
        program_registers(1'b1, 23'h7fffff, 23'h0fffff, 0, 1);
        send_frame(2, 2, 0);
        // Zero center gain with the most negative neighbor gain goes below zero.
        program_registers(1'b1, 23'h000000, 23'h100000, 1, 0);
        send_frame(2, 2, 0);
    endtask

    task automatic test_register_write_midframe();
        logic [CFG_DATA_BITS-1:0] cg;
        logic [CFG_DATA_BITS-1:0] ng;
        sender_idle_pct    = 12;
        receiver_stall_pct = 12;
        draw_gains(cg, ng);
        program_registers(1'b1, cg, ng, 4, 16'hffff);
        send_pixels(18, 0);
        // Both positions now lie outside the new size and start over.
        program_registers(1'b0, '0, '0, 2, 2);
        send_frame(2, 2, 6);
    endtask

    task automatic test_random_frames(int sender_pct, int receiver_pct, int budget);
        int                       stop_at;
        int                       w_raw;
        int                       h_raw;
        bit                       fresh;
        logic [CFG_DATA_BITS-1:0] cg;
        logic [CFG_DATA_BITS-1:0] ng;
        sender_idle_pct    = sender_pct;
        receiver_stall_pct = receiver_pct;
        stop_at = items_sent + budget;
        fresh   = 1'b1;
        while (items_sent < stop_at) begin
            // Some frames reuse the settings and follow the last one directly.
            if (fresh || $urandom_range(0, 3) != 0) begin
                fresh = 1'b0;
                draw_gains(cg, ng);
                case ($urandom_range(0, 9))
                    0:       w_raw = $urandom_range(0, 1);
                    1:       w_raw = $urandom_range(10, 40);
                    default: w_raw = $urandom_range(2, 9);
                endcase
                h_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1)
                                                    : $urandom_range(2, 5);
                program_registers(1'b1, cg, ng, {10'($urandom), WIDTH_BITS'(w_raw)},
                                  {7'($urandom), HEIGHT_BITS'(h_raw)});
            end
            send_frame(clamp_width(WIDTH_BITS'(w_raw)), clamp_height(HEIGHT_BITS'(h_raw)), 6);
        end
    endtask

    task automatic test_widest_line();
        logic [CFG_DATA_BITS-1:0] cg;
        logic [CFG_DATA_BITS-1:0] ng;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        draw_gains(cg, ng);
        // An all-ones width is held to the line store depth.
        program_registers(1'b1, cg, ng, 13'h1fff, 2);
        send_pixels(64, 6);
        // The column count lies past the new width and starts over.
        program_registers(1'b0, '0, '0, 3, 2);
        send_frame(3, 2, 0);
    endtask

    initial begin
        for (int i = 0; i < LINE_DEPTH; i++) begin
            upper_hist[i]  = '0;
            middle_hist[i] = '0;
        end
        for (int i = 0; i < 9; i++)
            taps[i] = '0;
        col_pos         = 0;
        row_pos         = 0;
        center_gain_m   = CENTER_GAIN_RST;
        neighbor_gain_m = NEIGHBOR_GAIN_RST;
        width_reg       = IMAGE_WIDTH_RST;
        height_reg      = IMAGE_HEIGHT_RST;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_default_gains();
        test_gain_extremes();
        test_register_write_midframe();
        test_random_frames(0, 0, 180);
        test_random_frames(65, 0, 180);
        test_random_frames(0, 65, 180);
        test_random_frames(12, 12, 180);
        test_widest_line();
        wait_for_drain();
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/shp_pkg.sv
rtl/core/shp_sequencer.sv
rtl/core/shp_window.sv
rtl/core/shp_kernel.sv
rtl/core/sharpen_3x3_rgba_filter.sv
bench/sharpen_3x3_rgba_filter_tb.sv
